// ===== rtl/preamble_crc8_frame_receiver_core_assert.svh =====
// Assertion macros used by the frame receiver parser.
// No dependencies; every macro compiles to nothing when NO_ASSERTIONS is set.
`ifndef PREAMBLE_CRC8_FRAME_RECEIVER_CORE_ASSERT_SVH
`define PREAMBLE_CRC8_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock, off during reset
`define PCFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pcfr assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define PCFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pcfr assertion failed");

`else

`define PCFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PCFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pcfr_pkg.sv =====
// Package for the preamble / CRC-8 frame receiver: types, constants, CRC step.
// No dependencies.
package pcfr_pkg;

  // Preamble pattern and CRC polynomial (x^8 + x^5 + x^4 + 1, top bit implied)
  localparam logic [7:0] Pre0    = 8'hAA;
  localparam logic [7:0] Pre1    = 8'hBB;
  localparam logic [7:0] Pre2    = 8'hCC;
  localparam logic [7:0] Pre3    = 8'hDD;
  localparam logic [7:0] CrcPoly = 8'h31;

  // Default receive buffer size
  localparam int BufferBytesDefault = 256;

  // Classification of each received byte
  typedef enum logic [1:0] {
    KindDrop    = 2'd0,
    KindHeader  = 2'd1,
    KindPayload = 2'd2
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] pbyte;
    logic [7:0] pidx;
    logic       fend;
    logic       cmatch;
    logic       lrej;
    logic [7:0] flen;
  } result_t;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/pcfr_in_stage.sv =====
// Input register of the frame receiver: holds one received byte.
// Depends on pcfr_pkg only by convention; no package items used.
module pcfr_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Register frees up whenever it is empty or its byte moves on
  assign in_stall_o = valid_q & ~adv_i;
  assign load       = ~in_stall_o;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Byte register, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/pcfr_parse.sv =====
// Frame parser: preamble hunt, length check, CRC-8 and per-byte classification.
// Depends on pcfr_pkg and the assertion macro header.
`include "preamble_crc8_frame_receiver_core_assert.svh"

module pcfr_parse #(
  parameter int BUFFER_BYTES = pcfr_pkg::BufferBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output pcfr_pkg::result_t res_o
);
  import pcfr_pkg::*;

  localparam logic [8:0] MaxLen = 9'(BUFFER_BYTES - 5);

  logic [8:0] pos_q, pos_d;
  logic       locked_q, locked_d;
  logic [7:0] pb1_q, pb1_d, pb2_q, pb2_d;
  logic [7:0] len_q, len_d, chk_q, chk_d, crc_q, crc_d;
  logic [8:0] p;
  logic [8:0] pidx_w;
  logic [7:0] crc_next;
  result_t    res;

  assign p        = pos_q + 9'd1;
  assign pidx_w   = p - 9'd7;
  assign crc_next = crc8_step(crc_q, byte_i);

  // Next state and result for the byte in the input register
  always_comb begin
    pos_d    = pos_q;
    locked_d = locked_q;
    pb1_d    = pb1_q;
    pb2_d    = pb2_q;
    len_d    = len_q;
    chk_d    = chk_q;
    crc_d    = crc_q;
    res      = '{kind: KindHeader, default: '0};

    priority if (p == 9'd1) begin
      // hunting for the first preamble byte
      if (byte_i != Pre0) begin
        res.kind = KindDrop;
        pos_d    = 9'd0;
        locked_d = 1'b0;
      end else begin
        pos_d = 9'd1;
      end
    end else if (p <= 9'd4) begin
      // inside the preamble
      if (!locked_q && byte_i == Pre0) begin
        pos_d = 9'd1;
      end else if (p == 9'd4) begin
        if (pb1_q == Pre1 && pb2_q == Pre2 && byte_i == Pre3) begin
          locked_d = 1'b1;
          pos_d    = 9'd4;
        end else begin
          res.kind = KindDrop;
          pos_d    = 9'd0;
        end
      end else if (p == 9'd2) begin
        pb1_d = byte_i;
        pos_d = p;
      end else begin
        pb2_d = byte_i;
        pos_d = p;
      end
    end else if (p == 9'd5) begin
      // length byte
      len_d    = byte_i;
      res.flen = byte_i;
      if ({1'b0, byte_i} > MaxLen || byte_i < 8'd2) begin
        res.lrej = 1'b1;
        pos_d    = 9'd0;
      end else begin
        pos_d = 9'd5;
      end
    end else if (p == 9'd6) begin
      // check byte
      chk_d    = byte_i;
      crc_d    = '0;
      res.flen = len_q;
      pos_d    = 9'd6;
    end else begin
      // type and data bytes
      res.kind  = KindPayload;
      res.pbyte = byte_i;
      res.pidx  = pidx_w[7:0];
      res.flen  = len_q;
      crc_d     = crc_next;
      if (p >= {1'b0, len_q} + 9'd5) begin
        res.fend   = 1'b1;
        res.cmatch = (crc_next == chk_q);
        pos_d      = 9'd0;
        locked_d   = 1'b0;
      end else begin
        pos_d = p;
      end
    end
  end

  // Frame position and lock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      locked_q <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      locked_q <= locked_d;
    end
  end

  // Header fields and CRC
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pb1_q <= pb1_d;
      pb2_q <= pb2_d;
      len_q <= len_d;
      chk_q <= chk_d;
      crc_q <= crc_d;
    end
  end

  assign res_o = res;

  `PCFR_ASSERT_NEXT(a_end_rewinds, clk_i, rst_ni, step_i && res.fend, pos_q == 9'd0 && !locked_q)
  `PCFR_ASSERT_NEXT(a_reject_rewinds, clk_i, rst_ni, step_i && res.lrej, pos_q == 9'd0 && locked_q)
  `PCFR_ASSERT_NOW(a_payload_pos, clk_i, rst_ni, step_i && res.kind == KindPayload, pos_q >= 9'd6)
  `PCFR_ASSERT_NOW(a_pos_bound, clk_i, rst_ni, pos_q >= 9'd6, pos_q <= {1'b0, len_q} + 9'd4)

endmodule

// ===== rtl/pcfr_out_stage.sv =====
// Result register of the frame receiver with its valid / stall handshake.
// Depends on pcfr_pkg for the result struct.
module pcfr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pcfr_pkg::result_t res_i,
  output logic              adv_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcfr_pkg::result_t res_o
);
  import pcfr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Loads whenever empty or the held result is taken this cycle
  assign adv_o   = ~valid_q | ~out_stall_i;
  assign valid_d = adv_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/preamble_crc8_frame_receiver_core.sv =====
// Input register holds a byte, then the result register its result; output stalls delay it.
// One byte per cycle unless output stalls; an empty input register loads while results wait.
// Per byte the parser does one pass of compare logic plus an 8-step XOR CRC.
// Reset (rst_ni, async, active low) empties both registers and restarts the hunt.
// Top level of the frame receiver: input register, parser, result register.
// Depends on pcfr_pkg, pcfr_in_stage, pcfr_parse and pcfr_out_stage.
module preamble_crc8_frame_receiver_core #(
  parameter int BUFFER_BYTES = pcfr_pkg::BufferBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] byte_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic       frame_end_o,
  output logic       crc_match_o,
  output logic       length_reject_o,
  output logic [7:0] frame_length_o
);
  import pcfr_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;
  logic       step;
  result_t    res_comb;
  result_t    res_out;

  pcfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  // Parser state moves only when its byte transfers to the result register
  assign step = s1_valid & adv;

  pcfr_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte),
    .res_o  (res_comb)
  );

  pcfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .res_i       (res_comb),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  // Result fields
  assign byte_kind_o     = res_out.kind;
  assign payload_byte_o  = res_out.pbyte;
  assign payload_index_o = res_out.pidx;
  assign frame_end_o     = res_out.fend;
  assign crc_match_o     = res_out.cmatch;
  assign length_reject_o = res_out.lrej;
  assign frame_length_o  = res_out.flen;

endmodule
